// ----- rtl/at_escape_packet_deframer_unit_macros.svh -----
// assertion macros for the deframer rtl
`ifndef AT_ESCAPE_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define AT_ESCAPE_PACKET_DEFRAMER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AEPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define AEPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/at_esc_pkg.sv -----
`default_nettype none

package at_esc_pkg;

  // length and colon limits
  localparam int MaxLength        = 999;
  localparam int FirstColonLimit  = 12;
  localparam int SecondColonLimit = 16;

  // header "+++AT", entry 0 is the first byte on the line
  localparam logic [4:0][7:0] HdrPat = {8'h54, 8'h41, 8'h2b, 8'h2b, 8'h2b};

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // frame phases
  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhCmd  = 3'd1;
  localparam logic [2:0] PhLen0 = 3'd2;
  localparam logic [2:0] PhPay  = 3'd3;
  localparam logic [2:0] PhCr   = 3'd4;
  localparam logic [2:0] PhLf   = 3'd5;
  localparam logic [2:0] PhLen1 = 3'd6;

  // error codes
  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrColon1 = 3'd1;
  localparam logic [2:0] ErrColon2 = 3'd2;
  localparam logic [2:0] ErrCrlf   = 3'd3;
  localparam logic [2:0] ErrLength = 3'd4;

  // results caused by one received byte
  typedef struct packed {
    logic [4:0][7:0] data;
    logic [2:0]      cnt;
    logic            kind;
    logic            pend;
    logic [2:0]      err;
  } grp_t;

endpackage

`default_nettype wire

// ----- rtl/at_esc_in_if.sv -----
`default_nettype none

interface at_esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/at_esc_out_if.sv -----
`default_nettype none

interface at_esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_kind;
  logic       packet_end;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (
    output valid, output out_byte, output byte_kind, output packet_end,
    output error_code, output last_of_run, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_kind, input packet_end,
    input error_code, input last_of_run, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/at_esc_parser.sv -----
`default_nettype none

module at_esc_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output at_esc_pkg::grp_t      grp_o
);

  logic [2:0] phase_q, phase_d;
  logic [2:0] hmc_q, hmc_d;
  logic [4:0] pos_q, pos_d;
  logic [9:0] acc_q, acc_d;
  logic [9:0] rem_q, rem_d;

  logic [2:0]      k;
  logic [2:0]      len;
  logic [4:0][7:0] s;
  logic [5:1]      ok;
  logic [2:0]      sel;
  logic [4:0]      pos_inc;
  logic [3:0]      dig;
  logic [13:0]     lval;
  logic            is_digit;

  // held header bytes plus the new byte
  always_comb begin
    k   = (hmc_q > 3'd4) ? 3'd0 : hmc_q;
    len = k + 3'd1;
    for (int j = 0; j < 5; j++) begin
      if (j < k) s[j] = at_esc_pkg::HdrPat[j];
      else if (j == k) s[j] = byte_i;
      else s[j] = 8'h00;
    end
  end

  // shortest release that leaves a header prefix
  always_comb begin
    for (int i = 1; i <= 5; i++) begin
      ok[i] = 1'b1;
      for (int j = 1; j < 5; j++) begin
        if (j >= i && j < len && s[j] != at_esc_pkg::HdrPat[j-i]) ok[i] = 1'b0;
      end
      if (i >= len) ok[i] = 1'b1;
    end
    sel = 3'd5;
    for (int i = 5; i >= 1; i--) begin
      if (ok[i]) sel = 3'(i);
    end
  end

  // length digit arithmetic
  assign pos_inc  = (pos_q == 5'd31) ? pos_q : pos_q + 5'd1;
  assign is_digit = (byte_i >= at_esc_pkg::ChZero) && (byte_i <= at_esc_pkg::ChNine);
  assign dig      = 4'(byte_i - at_esc_pkg::ChZero);
  assign lval     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {10'b0, dig};

  // next state and result group
  always_comb begin
    phase_d = phase_q;
    hmc_d   = hmc_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    grp_o.data = s;
    grp_o.data[0] = (phase_q == at_esc_pkg::PhHunt || phase_q == 3'd7) ? s[0] : byte_i;
    grp_o.cnt  = 3'd1;
    grp_o.kind = 1'b1;
    grp_o.pend = 1'b0;
    grp_o.err  = at_esc_pkg::ErrNone;

    unique case (phase_q)
      at_esc_pkg::PhCmd: begin
        if (byte_i == at_esc_pkg::ChColon) begin
          phase_d = at_esc_pkg::PhLen0;
          pos_d   = pos_inc;
        end else if (pos_q >= 5'(at_esc_pkg::FirstColonLimit - 1)) begin
          grp_o.err = at_esc_pkg::ErrColon1;
        end else begin
          pos_d = pos_inc;
        end
      end
      at_esc_pkg::PhLen0, at_esc_pkg::PhLen1: begin
        if (byte_i == at_esc_pkg::ChColon) begin
          if (phase_q == at_esc_pkg::PhLen0) begin
            grp_o.err = at_esc_pkg::ErrLength;
          end else begin
            rem_d   = acc_q;
            phase_d = (acc_q != 10'd0) ? at_esc_pkg::PhPay : at_esc_pkg::PhCr;
            pos_d   = pos_inc;
          end
        end else if (pos_q >= 5'(at_esc_pkg::SecondColonLimit - 1)) begin
          grp_o.err = at_esc_pkg::ErrColon2;
        end else if (!is_digit) begin
          grp_o.err = at_esc_pkg::ErrLength;
        end else if (lval > 14'(at_esc_pkg::MaxLength)) begin
          grp_o.err = at_esc_pkg::ErrLength;
        end else begin
          acc_d   = lval[9:0];
          phase_d = at_esc_pkg::PhLen1;
          pos_d   = pos_inc;
        end
      end
      at_esc_pkg::PhPay: begin
        rem_d = rem_q - 10'd1;
        if (rem_q == 10'd1) phase_d = at_esc_pkg::PhCr;
      end
      at_esc_pkg::PhCr: begin
        if (byte_i == at_esc_pkg::ChCr) phase_d = at_esc_pkg::PhLf;
        else grp_o.err = at_esc_pkg::ErrCrlf;
      end
      at_esc_pkg::PhLf: begin
        if (byte_i == at_esc_pkg::ChLf) begin
          grp_o.pend = 1'b1;
          phase_d    = at_esc_pkg::PhHunt;
          pos_d      = 5'd0;
          acc_d      = 10'd0;
          rem_d      = 10'd0;
        end else begin
          grp_o.err = at_esc_pkg::ErrCrlf;
        end
      end
      default: begin
        // hunting for the header
        phase_d = at_esc_pkg::PhHunt;
        if (byte_i == at_esc_pkg::HdrPat[k]) begin
          if (k < 3'd4) begin
            hmc_d     = k + 3'd1;
            grp_o.cnt = 3'd0;
          end else begin
            grp_o.cnt = 3'd5;
            hmc_d     = 3'd0;
            phase_d   = at_esc_pkg::PhCmd;
            pos_d     = 5'd5;
            acc_d     = 10'd0;
            rem_d     = 10'd0;
          end
        end else begin
          grp_o.cnt  = sel;
          grp_o.kind = 1'b0;
          hmc_d      = len - sel;
        end
      end
    endcase

    // any error drops back to hunting
    if (grp_o.err != at_esc_pkg::ErrNone) begin
      phase_d = at_esc_pkg::PhHunt;
      hmc_d   = 3'd0;
      pos_d   = 5'd0;
      acc_d   = 10'd0;
      rem_d   = 10'd0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= at_esc_pkg::PhHunt;
      hmc_q   <= 3'd0;
      pos_q   <= 5'd0;
      acc_q   <= 10'd0;
      rem_q   <= 10'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hmc_q   <= hmc_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/at_escape_packet_deframer_unit.sv -----
// AT escape packet deframer
// rx_i carries one received modem byte per beat (valid/ready). res_o carries
// one result per beat: the released byte, raw or packet tag, packet end on
// the closing line feed, an error code, and last_of_run on the final result
// caused by a given input byte.
// A received byte is parsed in the cycle it is accepted and its results
// (none, one, or up to five for a header release or a mismatch flush) are
// written to the head result slot, or to the spare slot while the head
// slot is busy; result beats are offered from the head slot. A byte that
// is only held as a possible header start gives no result.
// Throughput is one byte per cycle as long as each byte gives at most one
// result and res_o is ready; a group of n results goes out as n beats.
// Two result slots decouple the sides: rx_i.ready stays high while the spare
// slot is empty, so one more byte with results is taken while res_o is
// stalled, then ready drops until the waiting group starts to drain.
// Reset empties both slots and puts the parser in header hunt.
`default_nettype none
`include "at_escape_packet_deframer_unit_macros.svh"

module at_escape_packet_deframer_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  at_esc_in_if.sink    rx_i,
  at_esc_out_if.source res_o
);

  at_esc_pkg::grp_t grp;
  at_esc_pkg::grp_t hd_q, hd_d;
  at_esc_pkg::grp_t tl_q, tl_d;
  logic             hd_vld_q, hd_vld_d;
  logic             tl_vld_q, tl_vld_d;
  logic [2:0]       idx_q, idx_d;

  logic in_fire;
  logic push;
  logic out_fire;
  logic is_last;
  logic pop_last;
  logic hd_free;
  logic hd_err;

  // handshake
  assign rx_i.ready = !tl_vld_q;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign push       = in_fire && (grp.cnt != 3'd0);
  assign out_fire   = res_o.valid && res_o.ready;
  assign is_last    = (idx_q == (hd_q.cnt - 3'd1));
  assign pop_last   = out_fire && is_last;
  assign hd_free    = !hd_vld_q || pop_last;

  at_esc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .byte_i (rx_i.rx_byte),
    .grp_o  (grp)
  );

  // result slot control
  always_comb begin
    hd_d     = hd_q;
    tl_d     = tl_q;
    hd_vld_d = hd_vld_q;
    tl_vld_d = tl_vld_q;
    idx_d    = idx_q;
    if (hd_free) begin
      idx_d = 3'd0;
      if (tl_vld_q) begin
        hd_d     = tl_q;
        hd_vld_d = 1'b1;
        tl_vld_d = 1'b0;
      end else if (push) begin
        hd_d     = grp;
        hd_vld_d = 1'b1;
      end else begin
        hd_vld_d = 1'b0;
      end
    end else begin
      if (out_fire) idx_d = idx_q + 3'd1;
      if (push) begin
        tl_d     = grp;
        tl_vld_d = 1'b1;
      end
    end
  end

  // slot control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_vld_q <= 1'b0;
      tl_vld_q <= 1'b0;
      idx_q    <= 3'd0;
    end else begin
      hd_vld_q <= hd_vld_d;
      tl_vld_q <= tl_vld_d;
      idx_q    <= idx_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    hd_q <= hd_d;
    tl_q <= tl_d;
  end

  // output beat
  assign res_o.valid       = hd_vld_q;
  assign res_o.out_byte    = hd_q.data[idx_q];
  assign res_o.byte_kind   = hd_q.kind;
  assign res_o.packet_end  = hd_q.pend;
  assign res_o.error_code  = hd_q.err;
  assign res_o.last_of_run = is_last;

  // error beat in the head slot
  assign hd_err = hd_vld_q && (hd_q.err != at_esc_pkg::ErrNone);

  // checks
  `AEPD_ASSERT(a_tail_needs_head, tl_vld_q |-> hd_vld_q, "spare slot filled while head empty")
  `AEPD_ASSERT(a_idx_in_group, hd_vld_q |-> (idx_q < hd_q.cnt), "beat index past group size")
  `AEPD_ASSERT_NEVER(a_no_empty_group, hd_vld_q && (hd_q.cnt == 3'd0), "empty group in slot")
  `AEPD_ASSERT(a_error_is_single, hd_err |-> (hd_q.kind && is_last && !hd_q.pend), "bad error beat")

endmodule

`default_nettype wire

// ----- tb/sv/tb_at_escape_packet_deframer_unit.sv -----
`timescale 1ns / 1ps

module tb_at_escape_packet_deframer_unit;

  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 20;
  localparam int RandItems  = 400;

  // opening bytes: raw extremes, a near-miss header, a header behind an
  // extra plus, an empty length, then a zero length packet
  localparam logic [7:0] DirectedSeq [24] = '{
    8'h00, 8'hff, 8'h2b, 8'h2b, 8'h41,
    8'h2b, 8'h2b, 8'h2b, 8'h2b, 8'h41, 8'h54, 8'h3a, 8'h3a,
    8'h2b, 8'h2b, 8'h2b, 8'h41, 8'h54, 8'h78, 8'h3a, 8'h30, 8'h3a, 8'h0d, 8'h0a
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_kind;
    logic       packet_end;
    logic [2:0] error_code;
    logic       last_of_run;
  } deframe_result_t;

  typedef struct {
    logic [7:0] data;
    bit         hold;
  } rx_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       rx_valid_q  = 1'b0;
  logic [7:0] rx_byte_q   = 8'h00;
  logic       res_ready_q = 1'b0;

  at_esc_in_if  rx_if ();
  at_esc_out_if res_if ();

  assign rx_if.valid   = rx_valid_q;
  assign rx_if.rx_byte = rx_byte_q;
  assign res_if.ready  = res_ready_q;

  at_escape_packet_deframer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  rx_item_t        rx_pending[$];
  deframe_result_t expected_results[$];
  deframe_result_t step_results[$];
  int              bytes_queued   = 0;
  int              bytes_accepted = 0;
  int              mismatch_count = 0;

  // shadow parser state
  logic [2:0] hdr_held   = 3'd0;
  logic [7:0] held_bytes [4] = '{default: 8'h00};
  logic [2:0] frame_ph   = at_esc_pkg::PhHunt;
  logic [4:0] pkt_pos    = 5'd0;
  logic [9:0] len_acc    = 10'd0;
  logic [9:0] pay_left   = 10'd0;

  function automatic void emit(logic [7:0] b, logic kind, logic pend, logic [2:0] err);
    deframe_result_t r;
    r.out_byte    = b;
    r.byte_kind   = kind;
    r.packet_end  = pend;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void go_hunt();
    frame_ph = at_esc_pkg::PhHunt;
    hdr_held = 3'd0;
    pkt_pos  = 5'd0;
    len_acc  = 10'd0;
    pay_left = 10'd0;
  endfunction

  function automatic void reject(logic [7:0] b, logic [2:0] err);
    emit(b, 1'b1, 1'b0, err);
    go_hunt();
  endfunction

  function automatic void bump_pos();
    if (pkt_pos < 5'd31) pkt_pos = pkt_pos + 5'd1;
  endfunction

  // header search with prefix hold-back
  function automatic void hunt_byte(logic [7:0] b);
    logic [7:0] s [5];
    int k, len, i, j;
    bit ok;
    k = (hdr_held > 3'd4) ? 0 : int'(hdr_held);
    if (b == at_esc_pkg::HdrPat[k]) begin
      if (k < 4) begin
        held_bytes[k] = b;
        hdr_held = 3'(k + 1);
      end else begin
        for (j = 0; j < 4; j++) emit(held_bytes[j], 1'b1, 1'b0, at_esc_pkg::ErrNone);
        emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
        go_hunt();
        frame_ph = at_esc_pkg::PhCmd;
        pkt_pos  = 5'd5;
      end
    end else begin
      for (j = 0; j < k; j++) s[j] = held_bytes[j];
      s[k] = b;
      len = k + 1;
      // smallest shift that leaves a valid header prefix
      for (i = 1; i <= len; i++) begin
        ok = 1'b1;
        for (j = i; j < len; j++) begin
          if (s[j] != at_esc_pkg::HdrPat[j - i]) ok = 1'b0;
        end
        if (ok) break;
      end
      for (j = 0; j < i; j++) emit(s[j], 1'b0, 1'b0, at_esc_pkg::ErrNone);
      for (j = i; j < len; j++) held_bytes[j - i] = s[j];
      hdr_held = 3'(len - i);
    end
  endfunction

  // work out the results of one accepted byte
  function automatic void predict_byte(logic [7:0] b);
    int p, v;
    step_results.delete();
    p = int'(pkt_pos);
    case (frame_ph)
      at_esc_pkg::PhCmd: begin
        if (b == at_esc_pkg::ChColon) begin
          emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
          frame_ph = at_esc_pkg::PhLen0;
          bump_pos();
        end else if (p + 1 >= at_esc_pkg::FirstColonLimit) begin
          reject(b, at_esc_pkg::ErrColon1);
        end else begin
          emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
          bump_pos();
        end
      end
      at_esc_pkg::PhLen0, at_esc_pkg::PhLen1: begin
        if (b == at_esc_pkg::ChColon) begin
          if (frame_ph == at_esc_pkg::PhLen0) begin
            reject(b, at_esc_pkg::ErrLength);
          end else begin
            emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
            pay_left = len_acc;
            frame_ph = (pay_left != 10'd0) ? at_esc_pkg::PhPay : at_esc_pkg::PhCr;
            bump_pos();
          end
        end else if (p + 1 >= at_esc_pkg::SecondColonLimit) begin
          reject(b, at_esc_pkg::ErrColon2);
        end else if (b < at_esc_pkg::ChZero || b > at_esc_pkg::ChNine) begin
          reject(b, at_esc_pkg::ErrLength);
        end else begin
          v = int'(len_acc) * 10 + int'(b) - int'(at_esc_pkg::ChZero);
          if (v > at_esc_pkg::MaxLength || v > 1023) begin
            reject(b, at_esc_pkg::ErrLength);
          end else begin
            len_acc  = 10'(v);
            frame_ph = at_esc_pkg::PhLen1;
            emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
            bump_pos();
          end
        end
      end
      at_esc_pkg::PhPay: begin
        emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
        pay_left = pay_left - 10'd1;
        if (pay_left == 10'd0) frame_ph = at_esc_pkg::PhCr;
      end
      at_esc_pkg::PhCr: begin
        if (b == at_esc_pkg::ChCr) begin
          emit(b, 1'b1, 1'b0, at_esc_pkg::ErrNone);
          frame_ph = at_esc_pkg::PhLf;
        end else begin
          reject(b, at_esc_pkg::ErrCrlf);
        end
      end
      at_esc_pkg::PhLf: begin
        if (b == at_esc_pkg::ChLf) begin
          emit(b, 1'b1, 1'b1, at_esc_pkg::ErrNone);
          go_hunt();
        end else begin
          reject(b, at_esc_pkg::ErrCrlf);
        end
      end
      default: begin
        frame_ph = at_esc_pkg::PhHunt;
        hunt_byte(b);
      end
    endcase
    if (step_results.size() != 0) step_results[$].last_of_run = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // stimulus builders
  function automatic void add_byte(logic [7:0] b, bit hold = 1'b0);
    rx_item_t it;
    it.data = b;
    it.hold = hold;
    rx_pending.push_back(it);
    bytes_queued++;
  endfunction

  // bytes that matter to the parser show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return at_esc_pkg::HdrPat[0];
      1: return at_esc_pkg::HdrPat[3];
      2: return at_esc_pkg::HdrPat[4];
      3: return at_esc_pkg::ChColon;
      4: return at_esc_pkg::ChCr;
      5: return at_esc_pkg::ChLf;
      6: return 8'($urandom_range(int'(at_esc_pkg::ChZero), int'(at_esc_pkg::ChNine)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_header(int cmd_len);
    logic [7:0] c;
    for (int i = 0; i < 5; i++) add_byte(at_esc_pkg::HdrPat[i]);
    for (int i = 0; i < cmd_len; i++) begin
      do c = pick_byte(); while (c == at_esc_pkg::ChColon);
      add_byte(c);
    end
    add_byte(at_esc_pkg::ChColon);
  endfunction

  function automatic void add_decimal(int v, int zeros);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < zeros; i++) add_byte(at_esc_pkg::ChZero);
    for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
  endfunction

  // one packet, sometimes with a byte spoiled
  function automatic void add_packet();
    int cmd_len, plen, pick, first, spoil;
    cmd_len = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
    pick = $urandom_range(0, 99);
    if (pick < 80) plen = $urandom_range(0, 16);
    else if (pick < 96) plen = $urandom_range(17, 60);
    else plen = $urandom_range(61, 140);
    first = bytes_queued;
    add_header(cmd_len);
    add_decimal(plen, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    add_byte(at_esc_pkg::ChColon);
    for (int i = 0; i < plen; i++) add_byte(pick_byte());
    add_byte(at_esc_pkg::ChCr);
    add_byte(at_esc_pkg::ChLf);
    if ($urandom_range(0, 3) == 0) begin
      spoil = $urandom_range(rx_pending.size() - (bytes_queued - first),
                             rx_pending.size() - 1);
      rx_pending[spoil].data = pick_byte();
    end
  endfunction

  // upstream side: pending bytes with random gaps
  int tx_gap = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_rx
    rx_item_t nxt;
    bit send;
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
      rx_byte_q  <= 8'h00;
      tx_gap     <= 0;
    end else begin
      if (rx_valid_q && rx_if.ready) begin
        predict_byte(rx_byte_q);
        bytes_accepted++;
      end
      if (!rx_valid_q || rx_if.ready) begin
        send = 1'b0;
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (rx_pending.size() != 0 &&
                     !(rx_pending[0].hold && expected_results.size() != 0)) begin
          send = 1'b1;
        end
        if (send) begin
          nxt = rx_pending.pop_front();
          rx_byte_q <= nxt.data;
          if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 12);
        end
        rx_valid_q <= send;
      end
    end
  end

  // downstream side: random stalls and result check
  int  res_stall = 0;
  bit  res_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : sink_res
    deframe_result_t want;
    int stall;
    if (!rst_ni) begin
      res_ready_q <= 1'b0;
      res_stall   <= 0;
    end else begin
      stall = res_stall;
      if (res_if.valid && res_ready_q) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: out_byte %0h", res_if.out_byte);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h actual %0h", want.out_byte, res_if.out_byte);
            mismatch_count++;
          end
          if (res_if.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0h actual %0h", want.byte_kind, res_if.byte_kind);
            mismatch_count++;
          end
          if (res_if.packet_end !== want.packet_end) begin
            $error("packet_end: expected %0h actual %0h", want.packet_end,
                   res_if.packet_end);
            mismatch_count++;
          end
          if (res_if.error_code !== want.error_code) begin
            $error("error_code: expected %0h actual %0h", want.error_code,
                   res_if.error_code);
            mismatch_count++;
          end
          if (res_if.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0h actual %0h", want.last_of_run,
                   res_if.last_of_run);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) res_burst = ~res_burst;
        stall = res_burst ? 0 : $urandom_range(0, 12);
      end else if (stall != 0) begin
        stall = stall - 1;
      end
      res_stall   <= stall;
      res_ready_q <= (stall == 0);
    end
  end

  // watchdog on cycles without any beat
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_q && rx_if.ready) || (res_if.valid && res_ready_q)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int mode, stop_at;
    bit first_rand;
    foreach (DirectedSeq[i]) add_byte(DirectedSeq[i]);
    stop_at = bytes_queued + RandItems;
    first_rand = 1'b1;
    while (bytes_queued < stop_at) begin
      // sender waits for the result stream to drain now and then
      if (first_rand || $urandom_range(0, 29) == 0) add_byte(pick_byte(), 1'b1);
      first_rand = 1'b0;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        add_packet();
      end else if (mode < 65) begin
        // length values around the upper bound
        add_header($urandom_range(0, 2));
        add_decimal($urandom_range(990, 1023), 0);
        add_byte(($urandom_range(0, 1) == 0) ? at_esc_pkg::ChColon
                                             : 8'($urandom_range(0, 47)));
      end else if (mode < 80) begin
        repeat ($urandom_range(1, 8)) add_byte(pick_byte());
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != bytes_queued) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
